FILE: hw/rtl/i2cee_pkg.sv
// Shared types and constants for the I2C EEPROM master.
// No dependencies.
package i2cee_pkg;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_WRITE = 2'd2,
    FUNC_BYTE  = 2'd3
  } func_e;

  typedef enum logic [4:0] {
    P_IDLE, P_ST0, P_ST1, P_ST2, P_TX0, P_TX1, P_TX2, P_WA0, P_WA1, P_WA2,
    P_RX0, P_RX1, P_AK0, P_AK1, P_AK2, P_NK0, P_NK1, P_NK2, P_SP0, P_WB
  } phase_e;

  typedef enum logic [2:0] {
    T_RD_DEVW, T_RD_MEM, T_RD_DEVR, T_W_POLL, T_W_MEM, T_W_DATA
  } task_e;

  typedef enum logic [1:0] { S_FAIL, S_OK, S_POLL } stop_e;

  localparam logic [1:0] CFG_DEV  = 2'd0;
  localparam logic [1:0] CFG_PAGE = 2'd1;
  localparam logic [1:0] CFG_POLL = 2'd2;

  // Largest transfer length; longer counts saturate here
  localparam logic [8:0] MAX_TRANSFER = 9'd256;

  // Classified word handed from front to back.
  typedef struct packed {
    func_e      func;
    logic [7:0] mem_address;
    logic [8:0] byte_count;
    logic [7:0] write_byte;
    logic       sda_in;
  } cmd_t;

  // One result word.
  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       read_last;
    logic       need_byte;
    logic       busy_res;
    logic       done_res;
    logic       success;
  } res_t;

endpackage

FILE: hw/rtl/i2cee_front.sv
// Front end: accepts input words, saturates the byte count, queues them.
// Depends on i2cee_pkg.
module i2cee_front import i2cee_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] func_i,
  input  logic [7:0] mem_address_i,
  input  logic [8:0] byte_count_i,
  input  logic [7:0] write_byte_i,
  input  logic       sda_in_i,
  output logic       cmd_valid_o,
  input  logic       cmd_ready_i,
  output cmd_t       cmd_o
);

  // Two-entry queue
  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  cmd_t       in_cmd;
  logic       push, pop;

  always_comb begin
    in_cmd.func        = func_e'(func_i);
    in_cmd.mem_address = mem_address_i;
    in_cmd.byte_count  = (byte_count_i > MAX_TRANSFER) ? MAX_TRANSFER : byte_count_i;
    in_cmd.write_byte  = write_byte_i;
    in_cmd.sda_in      = sda_in_i;
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_cmd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue overfull");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> !in_ready_o) else $error("ready while full");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !pop) else $error("pop while empty");

endmodule

FILE: hw/rtl/i2cee_engine.sv
// Back end: bit-level I2C sequencer, one queued word per cycle unless the output stalls.
// Depends on i2cee_pkg.
module i2cee_engine import i2cee_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [6:0]  dev_addr_i,
  input  logic [3:0]  page_log2_i,
  input  logic [15:0] poll_limit_i,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  cmd_t        cmd_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output res_t        res_o
);

  phase_e      phase_q, phase_d;
  task_e       task_q, task_d;
  stop_e       stop_q, stop_d;
  logic [2:0]  bit_q, bit_d;
  logic [7:0]  sh_q, sh_d;
  logic [7:0]  addr_q, addr_d;
  logic [8:0]  left_q, left_d;
  logic [15:0] poll_q, poll_d;
  logic        scl_q, scl_d, sda_q, sda_d, ack_q, ack_d;
  logic        ev_valid, ev_last, ev_done, ev_ok;
  logic [7:0]  ev_byte;
  logic        step;
  res_t        out_q;
  logic        out_v_q;
  logic [7:0]  mask;
  logic [15:0] lim;
  logic [3:0]  shv;
  logic [7:0]  dev_byte;

  // Output register frees as it is taken
  assign cmd_ready_o = !out_v_q || res_ready_i;
  assign step        = cmd_valid_i && cmd_ready_o;
  assign res_valid_o = out_v_q;
  assign res_o       = out_q;

  assign shv      = (page_log2_i > 4'd8) ? 4'd8 : page_log2_i;
  assign mask     = 8'((9'd1 << shv) - 9'd1);
  assign lim      = (poll_limit_i == 16'd0) ? 16'd1 : poll_limit_i;
  assign dev_byte = {dev_addr_i, (task_q == T_RD_DEVR)};

  // Next-state logic, mirrors the bus sequencing
  always_comb begin
    logic [8:0] nleft;
    logic [7:0] naddr;
    phase_d = phase_q; task_d = task_q; stop_d = stop_q; bit_d = bit_q;
    sh_d = sh_q; addr_d = addr_q; left_d = left_q; poll_d = poll_q;
    scl_d = scl_q; sda_d = sda_q; ack_d = ack_q;
    ev_valid = 1'b0; ev_last = 1'b0; ev_done = 1'b0; ev_ok = 1'b0; ev_byte = 8'd0;
    nleft = 9'd0; naddr = 8'd0;
    unique case (cmd_i.func)
      FUNC_TICK: begin
        unique case (phase_q)
          P_ST0: begin phase_d = P_ST1; sda_d = 1'b0; end
          P_ST1: begin phase_d = P_ST2; scl_d = 1'b0; end
          P_ST2: begin
            sh_d = dev_byte; bit_d = 3'd0; phase_d = P_TX0; sda_d = dev_byte[7];
          end
          P_TX0: begin phase_d = P_TX1; scl_d = 1'b1; end
          P_TX1: begin
            phase_d = P_TX2; scl_d = 1'b0;
            if (bit_q == 3'd7) sda_d = 1'b1;
            sh_d = {sh_q[6:0], 1'b0};
          end
          P_TX2: begin
            if (bit_q == 3'd7) begin phase_d = P_WA0; sda_d = 1'b1; end
            else begin bit_d = bit_q + 3'd1; phase_d = P_TX0; sda_d = sh_q[7]; end
          end
          P_WA0: begin phase_d = P_WA1; scl_d = 1'b1; end
          P_WA1: begin ack_d = cmd_i.sda_in; phase_d = P_WA2; scl_d = 1'b0; end
          P_WA2: begin
            if (ack_q) begin
              if (task_q == T_W_POLL && (poll_q + 16'd1) < lim) begin
                poll_d = poll_q + 16'd1;
                phase_d = P_ST0; sda_d = 1'b1; scl_d = 1'b1;
              end else begin
                if (task_q == T_W_POLL) poll_d = poll_q + 16'd1;
                stop_d = S_FAIL; phase_d = P_SP0; sda_d = 1'b0; scl_d = 1'b1;
              end
            end else begin
              unique case (task_q)
                T_RD_DEVW, T_W_POLL: begin
                  task_d = (task_q == T_RD_DEVW) ? T_RD_MEM : T_W_MEM;
                  sh_d = addr_q; bit_d = 3'd0; phase_d = P_TX0; sda_d = addr_q[7];
                end
                T_RD_MEM: begin
                  task_d = T_RD_DEVR; phase_d = P_ST0; sda_d = 1'b1; scl_d = 1'b1;
                end
                T_RD_DEVR: begin
                  if (left_q == 9'd0) begin
                    stop_d = S_OK; phase_d = P_SP0; sda_d = 1'b0; scl_d = 1'b1;
                  end else begin
                    bit_d = 3'd0; sh_d = 8'd0; phase_d = P_RX0; scl_d = 1'b1;
                  end
                end
                T_W_MEM: begin task_d = T_W_DATA; phase_d = P_WB; end
                default: begin
                  naddr = addr_q + 8'd1;
                  nleft = (left_q != 9'd0) ? left_q - 9'd1 : 9'd0;
                  addr_d = naddr; left_d = nleft;
                  if (nleft == 9'd0) begin
                    stop_d = S_OK; phase_d = P_SP0; sda_d = 1'b0; scl_d = 1'b1;
                  end else if ((naddr & mask) == 8'd0) begin
                    stop_d = S_POLL; phase_d = P_SP0; sda_d = 1'b0; scl_d = 1'b1;
                  end else begin
                    phase_d = P_WB;
                  end
                end
              endcase
            end
          end
          P_RX0: begin
            sh_d = {sh_q[6:0], cmd_i.sda_in}; phase_d = P_RX1; scl_d = 1'b0;
          end
          P_RX1: begin
            if (bit_q != 3'd7) begin
              bit_d = bit_q + 3'd1; phase_d = P_RX0; scl_d = 1'b1;
            end else begin
              nleft = (left_q != 9'd0) ? left_q - 9'd1 : 9'd0;
              left_d = nleft;
              ev_valid = 1'b1; ev_byte = sh_q; ev_last = (nleft == 9'd0);
              phase_d = ev_last ? P_NK0 : P_AK0;
              sda_d = ev_last;
            end
          end
          P_AK0: begin phase_d = P_AK1; scl_d = 1'b1; end
          P_AK1: begin phase_d = P_AK2; scl_d = 1'b0; end
          P_AK2: begin
            sda_d = 1'b1; bit_d = 3'd0; sh_d = 8'd0; phase_d = P_RX0; scl_d = 1'b1;
          end
          P_NK0: begin phase_d = P_NK1; scl_d = 1'b1; end
          P_NK1: begin phase_d = P_NK2; scl_d = 1'b0; end
          P_NK2: begin stop_d = S_OK; phase_d = P_SP0; sda_d = 1'b0; scl_d = 1'b1; end
          P_SP0: begin
            sda_d = 1'b1;
            if (stop_q == S_POLL) begin
              poll_d = 16'd0; task_d = T_W_POLL; phase_d = P_ST0; scl_d = 1'b1;
            end else begin
              phase_d = P_IDLE; ev_done = 1'b1; ev_ok = (stop_q == S_OK);
            end
          end
          default: ;
        endcase
      end
      FUNC_BYTE: begin
        if (phase_q == P_WB) begin
          sh_d = cmd_i.write_byte; bit_d = 3'd0; phase_d = P_TX0;
          sda_d = cmd_i.write_byte[7];
        end
      end
      default: begin
        if (phase_q == P_IDLE) begin
          addr_d = cmd_i.mem_address; left_d = cmd_i.byte_count; poll_d = 16'd0;
          if (cmd_i.func == FUNC_READ) begin
            task_d = T_RD_DEVW; phase_d = P_ST0; sda_d = 1'b1; scl_d = 1'b1;
          end else begin
            task_d = T_W_DATA; phase_d = P_SP0; sda_d = 1'b0; scl_d = 1'b1;
            stop_d = (cmd_i.byte_count == 9'd0) ? S_OK : S_POLL;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_IDLE; task_q <= T_RD_DEVW; stop_q <= S_FAIL;
      bit_q <= 3'd0; sh_q <= 8'd0; addr_q <= 8'd0; left_q <= 9'd0;
      poll_q <= 16'd0; scl_q <= 1'b1; sda_q <= 1'b1; ack_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (step) begin
        phase_q <= phase_d; task_q <= task_d; stop_q <= stop_d;
        bit_q <= bit_d; sh_q <= sh_d; addr_q <= addr_d; left_q <= left_d;
        poll_q <= poll_d; scl_q <= scl_d; sda_q <= sda_d; ack_q <= ack_d;
        out_v_q <= 1'b1;
      end else if (res_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Result word register
  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q.scl        <= scl_d;
      out_q.sda_out    <= sda_d;
      out_q.read_byte  <= ev_byte;
      out_q.read_valid <= ev_valid;
      out_q.read_last  <= ev_last;
      out_q.need_byte  <= (phase_d == P_WB);
      out_q.busy_res   <= (phase_d != P_IDLE);
      out_q.done_res   <= ev_done;
      out_q.success    <= ev_ok;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && ev_done) |=> (phase_q == P_IDLE)) else $error("done not idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !res_ready_i) |-> !step) else $error("result overwritten");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == P_WB) |-> (task_q == T_W_DATA)) else $error("byte wait bad task");

endmodule

FILE: hw/rtl/i2c_eeprom_master_top.sv
// Top level of the I2C EEPROM master: config registers, front queue, engine.
// Depends on i2cee_pkg, i2cee_front, i2cee_engine.
//
//  port group   dir  words
//  cfg_*        in   register index + data
//  in_*         in   tick, command or write-byte word
//  out_*        out  pin levels and status word, one per input word
//
// One input word per cycle sustained unless the output stalls. An accepted
// word waits in the front queue, then the engine steps it into the result
// register. The engine advances at most one phase per word.
// Reset sets config to defaults, bus released, engine idle, queue empty.
// An output stall holds the engine; the two-entry queue then fills.
module i2c_eeprom_master_top import i2cee_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  mem_address_i,
  input  logic [8:0]  byte_count_i,
  input  logic [7:0]  write_byte_i,
  input  logic        sda_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        scl_o,
  output logic        sda_out_o,
  output logic [7:0]  read_byte_o,
  output logic        read_valid_o,
  output logic        read_last_o,
  output logic        need_byte_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic        success_o
);

  logic [6:0]  dev_q;
  logic [3:0]  page_q;
  logic [15:0] poll_q;
  logic        cmd_valid, cmd_ready;
  cmd_t        cmd;
  res_t        res;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_q  <= 7'd80;
      page_q <= 4'd3;
      poll_q <= 16'd1000;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DEV:  dev_q  <= cfg_data_i[6:0];
        CFG_PAGE: page_q <= cfg_data_i[3:0];
        CFG_POLL: poll_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  i2cee_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .func_i, .mem_address_i,
    .byte_count_i, .write_byte_i, .sda_in_i,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  i2cee_engine u_engine (
    .clk_i, .rst_ni, .dev_addr_i(dev_q), .page_log2_i(page_q),
    .poll_limit_i(poll_q), .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready),
    .cmd_i(cmd), .res_valid_o(out_valid_o), .res_ready_i(out_ready_i), .res_o(res)
  );

  assign scl_o        = res.scl;
  assign sda_out_o    = res.sda_out;
  assign read_byte_o  = res.read_byte;
  assign read_valid_o = res.read_valid;
  assign read_last_o  = res.read_last;
  assign need_byte_o  = res.need_byte;
  assign busy_res_o   = res.busy_res;
  assign done_res_o   = res.done_res;
  assign success_o    = res.success;

endmodule
